@@ rtl/bbrb_pkg.sv @@
// ----------------------------------------------------------------------------
// bbrb_pkg
// Shared constants and types of the replicated-border box blur.
// ----------------------------------------------------------------------------
package bbrb_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_KERNEL_DEF = 15;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;

  localparam int unsigned NCH        = 3;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned KCFG_W     = 4;
  localparam int unsigned SIZE_W     = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [KCFG_W-1:0] KERNEL_RST = KCFG_W'(3);
  localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef logic [NCH*PIX_W-1:0] pix_t;

endpackage

@@ rtl/bbrb_if.sv @@
// ----------------------------------------------------------------------------
// bbrb_if
// Valid/ready channels of the box blur: pixel input, result output, register
// writes.
// ----------------------------------------------------------------------------
interface bbrb_pix_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [bbrb_pkg::PIX_W-1:0] in_blue;
  logic [bbrb_pkg::PIX_W-1:0] in_green;
  logic [bbrb_pkg::PIX_W-1:0] in_red;
  modport source (output valid, mode, in_blue, in_green, in_red, input ready);
  modport sink   (input valid, mode, in_blue, in_green, in_red, output ready);
endinterface

interface bbrb_res_if;
  logic                       valid;
  logic                       ready;
  logic [bbrb_pkg::PIX_W-1:0] out_blue;
  logic [bbrb_pkg::PIX_W-1:0] out_green;
  logic [bbrb_pkg::PIX_W-1:0] out_red;
  logic                       run_last;
  logic                       frame_last;
  modport source (output valid, out_blue, out_green, out_red, run_last, frame_last,
                  input ready);
  modport sink   (input valid, out_blue, out_green, out_red, run_last, frame_last,
                  output ready);
endinterface

interface bbrb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bbrb_pkg::CFG_IDX_W-1:0]  index;
  logic [bbrb_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/bbrb_ram.sv @@
// ----------------------------------------------------------------------------
// bbrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bbrb_cell.sv @@
// ----------------------------------------------------------------------------
// bbrb_cell
// One column of the horizontal window: holds a vertical column sum of all
// channels and takes its neighbour's value on each shift, or the new sum on fill.
// ----------------------------------------------------------------------------
module bbrb_cell #(
  parameter int unsigned VSW = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          fill_i,
  input  logic [bbrb_pkg::NCH*VSW-1:0]  vs_i,
  input  logic [bbrb_pkg::NCH*VSW-1:0]  prev_i,
  output logic [bbrb_pkg::NCH*VSW-1:0]  q_o
);
  import bbrb_pkg::*;

  logic [NCH*VSW-1:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (en_i) begin
      val_q <= fill_i ? vs_i : prev_i;
    end
  end

  assign q_o = val_q;

endmodule

@@ rtl/bbrb_div.sv @@
// ----------------------------------------------------------------------------
// bbrb_div
// Restoring divider, one quotient bit per cycle, all channels side by side.
// The quotient is known to fit in one pixel.
// ----------------------------------------------------------------------------
module bbrb_div #(
  parameter int unsigned SUMW  = 16,
  parameter int unsigned AREAW = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [bbrb_pkg::NCH*SUMW-1:0]         dividend_i,
  input  logic [AREAW-1:0]                      divisor_i,
  output logic                                  done_o,
  output logic [bbrb_pkg::NCH*bbrb_pkg::PIX_W-1:0] quot_o
);
  import bbrb_pkg::*;

  localparam int unsigned CW = $clog2(PIX_W);

  logic [SUMW-1:0]      rem_q [NCH];
  logic [SUMW-1:0]      dv_q;
  logic [NCH*PIX_W-1:0] quot_q;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q;
  logic                 done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(PIX_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dv_q <= SUMW'(divisor_i) << (PIX_W - 1);
      for (int c = 0; c < NCH; c++) begin
        rem_q[c] <= dividend_i[c*SUMW +: SUMW];
      end
    end else if (busy_q) begin
      dv_q <= dv_q >> 1;
      for (int c = 0; c < NCH; c++) begin
        if (rem_q[c] >= dv_q) begin
          rem_q[c] <= rem_q[c] - dv_q;
          quot_q[c*PIX_W +: PIX_W] <= {quot_q[c*PIX_W +: PIX_W-1], 1'b1};
        end else begin
          quot_q[c*PIX_W +: PIX_W] <= {quot_q[c*PIX_W +: PIX_W-1], 1'b0};
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ rtl/box_blur_replicate_border.sv @@
// ----------------------------------------------------------------------------
// box_blur_replicate_border
// K-by-K mean filter over a raster stream of blue/green/red pixels with
// replicated image borders.
//
// Usage: pixels enter on pix_in in raster order (mode 0). After the last
// image row the source sends K/2 rows of drain items (mode 1) standing for
// replicated bottom rows. An item of the wrong kind is dropped. Results
// leave on res_out; run_last marks the last result of an input item and
// frame_last the last pixel of the frame. Registers (kernel size, width,
// height) are to be written on cfg only while idle; the block does not
// enforce this. A write while idle restarts the frame. One item at a time
// is worked on; its time goes to the line-buffer and column-sum memory
// accesses, the window shift, the bit-serial divider (one quotient bit a
// cycle) for each result and a step for each skipped right-border column;
// the first image row also writes the remaining line-buffer rows. A row
// end gives a burst of up to K/2+1 results. The result register holds its
// item while the receiver stalls, the next input item is taken meanwhile.
// Reset restores the default registers and clears the counters and the
// window; memories need no clearing.
// ----------------------------------------------------------------------------
module box_blur_replicate_border #(
  parameter int unsigned MAX_WIDTH  = bbrb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_KERNEL = bbrb_pkg::MAX_KERNEL_DEF,
  parameter int unsigned MAX_HEIGHT = bbrb_pkg::MAX_HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bbrb_pix_if.sink   pix_in,
  bbrb_res_if.source res_out,
  bbrb_cfg_if.sink   cfg
);
  import bbrb_pkg::*;

  localparam int unsigned HMAX      = (MAX_KERNEL - 1) / 2;
  localparam int unsigned LINE_ROWS = MAX_KERNEL - 1;
  localparam int unsigned LDEPTH    = LINE_ROWS * MAX_WIDTH;
  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned WCW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HCW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT + HMAX + 1);
  localparam int unsigned HW    = $clog2(HMAX + 1);
  localparam int unsigned SW    = $clog2(LINE_ROWS);
  localparam int unsigned KW    = $clog2(MAX_KERNEL);
  localparam int unsigned LAW   = $clog2(LDEPTH);
  localparam int unsigned PMAX  = (2 ** PIX_W) - 1;
  localparam int unsigned VSW   = $clog2(MAX_KERNEL * PMAX + 1);
  localparam int unsigned SUMW  = $clog2(MAX_KERNEL * MAX_KERNEL * PMAX + 1);
  localparam int unsigned AREAW = $clog2(MAX_KERNEL * MAX_KERNEL + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_R1, S_UPD, S_WIN, S_FILL, S_EMIT, S_DIV, S_SEND
  } state_e;

  state_e state_q;

  logic [KCFG_W-1:0] kcfg_q;
  logic [SIZE_W-1:0] wcfg_q;
  logic [SIZE_W-1:0] hcfg_q;
  logic              cfg_hit;

  logic [KCFG_W-1:0] hraw;
  logic [HW-1:0]     h_eff;
  logic [HW:0]       rows2;
  logic [HW:0]       kval;
  logic [WCW-1:0]    w_eff;
  logic [HCW-1:0]    hgt_eff;
  logic [AREAW-1:0]  area_q;

  logic [XW-1:0]  x_q;
  logic [YW-1:0]  y_q;
  logic [SW-1:0]  slot_q;
  logic [SW-1:0]  bottom_q;
  logic [SW-1:0]  fill_q;
  logic [HW-1:0]  d_q;
  logic           drain;
  logic           y0;
  logic           x0;
  logic           row_end;
  logic           y_emit;
  logic           emit;
  logic           accept;

  pix_t               v_q;
  logic [NCH*VSW-1:0] vs_d;
  logic [NCH*VSW-1:0] vs_q;
  logic [NCH*VSW-1:0] csn_d;
  logic [NCH*SUMW-1:0] s_q;
  logic [NCH*SUMW-1:0] s_d;
  logic [NCH*SUMW-1:0] t_q;
  logic [NCH*SUMW-1:0] t_step;
  logic [NCH*VSW-1:0] win [MAX_KERNEL];
  logic [NCH*VSW-1:0] win_tail;
  logic [NCH*VSW-1:0] win_drop;
  logic               win_en;

  logic           ls_we;
  logic [LAW-1:0] ls_waddr;
  logic           ls_re;
  logic [LAW-1:0] ls_raddr;
  logic [SW-1:0]  ls_rslot;
  logic [SW-1:0]  ls_wslot;
  pix_t           ls_rdata;
  logic           cs_we;
  logic           cs_re;
  logic [NCH*VSW-1:0] cs_rdata;

  logic               div_start;
  logic               div_done;
  logic [NCH*PIX_W-1:0] div_quot;

  logic [XW-1:0] x_adv;
  logic [YW-1:0] y_adv;
  logic [SW-1:0] slot_adv;

  pix_t out_q;
  logic out_valid_q;
  logic run_last_q;
  logic frame_last_q;
  logic out_free;
  logic is_last;

  // Register file
  assign cfg.ready = 1'b1;
  assign cfg_hit = cfg.valid && (cfg.index == CFG_KERNEL || cfg.index == CFG_WIDTH ||
                                 cfg.index == CFG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kcfg_q <= KERNEL_RST;
      wcfg_q <= WIDTH_RST;
      hcfg_q <= HEIGHT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_KERNEL: kcfg_q <= cfg.data[KCFG_W-1:0];
        CFG_WIDTH:  wcfg_q <= cfg.data[SIZE_W-1:0];
        CFG_HEIGHT: hcfg_q <= cfg.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hraw    = (kcfg_q < KCFG_W'(3)) ? KCFG_W'(1) : ((kcfg_q - KCFG_W'(1)) >> 1);
    h_eff   = (32'(hraw) > HMAX) ? HW'(HMAX) : HW'(hraw);
    rows2   = {h_eff, 1'b0};
    kval    = {h_eff, 1'b1};
    w_eff   = (wcfg_q == '0) ? WCW'(1) :
              (32'(wcfg_q) > MAX_WIDTH) ? WCW'(MAX_WIDTH) : WCW'(wcfg_q);
    hgt_eff = (hcfg_q == '0) ? HCW'(1) :
              (32'(hcfg_q) > MAX_HEIGHT) ? HCW'(MAX_HEIGHT) : HCW'(hcfg_q);
  end

  always_ff @(posedge clk_i) begin
    area_q <= AREAW'(kval) * AREAW'(kval);
  end

  // Position flags
  assign drain   = y_q >= YW'(hgt_eff);
  assign y0      = y_q == '0;
  assign x0      = x_q == '0;
  assign row_end = WCW'(x_q) == (w_eff - 1'b1);
  assign y_emit  = y_q >= YW'(h_eff);
  assign emit    = y_emit && (row_end ? (XW'(d_q) <= x_q) : (x_q >= XW'(h_eff)));
  assign accept  = pix_in.valid && pix_in.ready;
  assign pix_in.ready = state_q == S_IDLE;
  assign out_free = !out_valid_q || res_out.ready;
  assign is_last  = !row_end || d_q == '0;

  always_comb begin
    x_adv    = x_q + 1'b1;
    y_adv    = y_q;
    slot_adv = slot_q;
    if (row_end) begin
      x_adv    = '0;
      y_adv    = y_q + 1'b1;
      slot_adv = (32'(slot_q) + 1 == 32'(rows2)) ? '0 : slot_q + 1'b1;
      if (y_adv >= YW'(hgt_eff) + YW'(h_eff)) begin
        y_adv    = '0;
        slot_adv = '0;
      end
    end
  end

  // Memories
  assign ls_rslot = (state_q == S_IDLE && drain) ? bottom_q : slot_q;
  assign ls_re    = accept || (state_q == S_R1 && drain);
  assign ls_raddr = LAW'(ls_rslot) * LAW'(MAX_WIDTH) + LAW'(x_q);
  assign ls_wslot = (state_q == S_FILL) ? fill_q : (y0 ? '0 : slot_q);
  assign ls_we    = state_q == S_UPD || state_q == S_FILL;
  assign ls_waddr = LAW'(ls_wslot) * LAW'(MAX_WIDTH) + LAW'(x_q);
  assign cs_re    = accept;
  assign cs_we    = state_q == S_UPD;

  bbrb_ram #(.WIDTH(NCH * PIX_W), .DEPTH(LDEPTH)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (ls_waddr),
    .wdata_i (v_q),
    .re_i    (ls_re),
    .raddr_i (ls_raddr),
    .rdata_o (ls_rdata)
  );

  bbrb_ram #(.WIDTH(NCH * VSW), .DEPTH(MAX_WIDTH)) u_colsum_ram (
    .clk_i   (clk_i),
    .we_i    (cs_we),
    .waddr_i (x_q),
    .wdata_i (csn_d),
    .re_i    (cs_re),
    .raddr_i (x_q),
    .rdata_o (cs_rdata)
  );

  // Vertical sums
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (y0) begin
        vs_d[c*VSW +: VSW]  = VSW'(kval) * VSW'(v_q[c*PIX_W +: PIX_W]);
        csn_d[c*VSW +: VSW] = VSW'(rows2) * VSW'(v_q[c*PIX_W +: PIX_W]);
      end else begin
        vs_d[c*VSW +: VSW]  = cs_rdata[c*VSW +: VSW] + VSW'(v_q[c*PIX_W +: PIX_W]);
        csn_d[c*VSW +: VSW] = vs_d[c*VSW +: VSW] - VSW'(ls_rdata[c*PIX_W +: PIX_W]);
      end
    end
  end

  // Window chain
  assign win_en = state_q == S_WIN;

  for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_cell
    bbrb_cell #(.VSW(VSW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (win_en),
      .fill_i (x0),
      .vs_i   (vs_q),
      .prev_i ((j == 0) ? vs_q : win[(j == 0) ? 0 : j - 1]),
      .q_o    (win[j])
    );
  end

  assign win_tail = win[KW'(rows2)];
  assign win_drop = win[KW'(d_q) + KW'(h_eff)];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (x0) begin
        s_d[c*SUMW +: SUMW] = SUMW'(kval) * SUMW'(vs_q[c*VSW +: VSW]);
      end else begin
        s_d[c*SUMW +: SUMW] = s_q[c*SUMW +: SUMW] - SUMW'(win_tail[c*VSW +: VSW])
                              + SUMW'(vs_q[c*VSW +: VSW]);
      end
      t_step[c*SUMW +: SUMW] = t_q[c*SUMW +: SUMW] - SUMW'(win_drop[c*VSW +: VSW])
                               + SUMW'(win[0][c*VSW +: VSW]);
    end
  end

  // Divider
  assign div_start = state_q == S_EMIT && emit;

  bbrb_div #(.SUMW(SUMW), .AREAW(AREAW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (t_q),
    .divisor_i  (area_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      slot_q      <= '0;
      bottom_q    <= '0;
      fill_q      <= '0;
      d_q         <= '0;
      s_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && res_out.ready && !(state_q == S_SEND && out_free)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cfg_hit) begin
            x_q    <= '0;
            y_q    <= '0;
            slot_q <= '0;
          end else if (accept && (pix_in.mode == drain)) begin
            state_q <= S_R1;
          end
        end
        S_R1: state_q <= S_UPD;
        S_UPD: begin
          if (y_q == YW'(hgt_eff) - 1'b1) begin
            bottom_q <= slot_q;
          end
          state_q <= S_WIN;
        end
        S_WIN: begin
          s_q <= s_d;
          d_q <= h_eff;
          if (y0) begin
            fill_q  <= SW'(1);
            state_q <= S_FILL;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_FILL: begin
          fill_q <= fill_q + 1'b1;
          if (32'(fill_q) + 1 == 32'(rows2)) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            state_q <= S_DIV;
          end else if (!row_end || !y_emit || d_q == '0) begin
            x_q     <= x_adv;
            y_q     <= y_adv;
            slot_q  <= slot_adv;
            state_q <= S_IDLE;
          end else begin
            d_q <= d_q - 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_SEND;
          end
        end
        S_SEND: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (is_last) begin
              x_q     <= x_adv;
              y_q     <= y_adv;
              slot_q  <= slot_adv;
              state_q <= S_IDLE;
            end else begin
              d_q     <= d_q - 1'b1;
              state_q <= S_EMIT;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q <= {pix_in.in_red, pix_in.in_green, pix_in.in_blue};
    end else if (state_q == S_R1 && drain) begin
      v_q <= ls_rdata;
    end
    if (state_q == S_UPD) begin
      vs_q <= vs_d;
    end
    if (state_q == S_WIN) begin
      t_q <= s_d;
    end else if ((state_q == S_EMIT && !emit) || (state_q == S_SEND && out_free)) begin
      t_q <= t_step;
    end
    if (state_q == S_SEND && out_free) begin
      out_q        <= div_quot;
      run_last_q   <= is_last;
      frame_last_q <= row_end && d_q == '0 &&
                      y_q == YW'(hgt_eff) + YW'(h_eff) - 1'b1;
    end
  end

  assign res_out.valid      = out_valid_q;
  assign res_out.out_blue   = out_q[0*PIX_W +: PIX_W];
  assign res_out.out_green  = out_q[1*PIX_W +: PIX_W];
  assign res_out.out_red    = out_q[2*PIX_W +: PIX_W];
  assign res_out.run_last   = run_last_q;
  assign res_out.frame_last = frame_last_q;

endmodule
